/* rtl/ftcs_pkg.sv */
// ----------------------------------------------------------------------------
// Floppy track cache sequencer package
// Shared constants, command and opcode codes, microcode words and the
// microprogram itself for the track cache sequencer.
// ----------------------------------------------------------------------------
package ftcs_pkg;

  // Geometry of the drive and widths of the request fields.
  localparam int SECTORS      = 11;
  localparam int TRACKS       = 160;
  localparam int SECTOR_BYTES = 512;
  localparam int TRK_W        = 8;
  localparam int SEC_W        = 4;
  localparam int OFF_W        = 9;
  localparam int CNT_W        = 10;
  localparam int UPC_W        = 5;

  localparam logic [SEC_W-1:0] LAST_SECTOR = SEC_W'(SECTORS - 1);
  localparam logic [TRK_W-1:0] PRECOMP_RESET = 8'd80;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_IDLE   = 2'd1,
    OP_HOME   = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  // Drive command codes.
  typedef enum logic [3:0] {
    CMD_MOTOR_ON    = 4'd0,
    CMD_MOTOR_OFF   = 4'd1,
    CMD_SIDE        = 4'd2,
    CMD_DIRECTION   = 4'd3,
    CMD_STEP        = 4'd4,
    CMD_READ_TRACK  = 4'd5,
    CMD_DECODE      = 4'd6,
    CMD_READ_BYTES  = 4'd7,
    CMD_WRITE_BYTES = 4'd8,
    CMD_ENCODE      = 4'd9,
    CMD_REALIGN     = 4'd10,
    CMD_WRITE_TRACK = 4'd11,
    CMD_HOME        = 4'd12,
    CMD_PROT_ERR    = 4'd13
  } cmd_e;

  // Datapath actions selected by a microcode word.
  typedef enum logic [4:0] {
    ACT_NOP,
    ACT_MOTOR_ON,
    ACT_MOTOR_OFF,
    ACT_POS_SIDE,
    ACT_POS_DIR,
    ACT_POS_STEP,
    ACT_READ_TRACK,
    ACT_DECODE,
    ACT_XFER,
    ACT_WT_BEGIN,
    ACT_ENCODE,
    ACT_REALIGN,
    ACT_WRITE_TRACK,
    ACT_DIR_OUT,
    ACT_HOME,
    ACT_DIR_IN,
    ACT_SIDE_LOW,
    ACT_FINISH
  } act_e;

  // Branch conditions of a microcode word.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_BAD_RANGE,
    C_ZERO_CNT,
    C_HIT,
    C_WRAP,
    C_NO_FLUSH,
    C_PROT,
    C_ENC_MORE
  } cond_e;

  typedef logic [UPC_W-1:0] upc_t;

  // One microcode word: action, branch condition, target select, branch target.
  typedef struct packed {
    act_e  act;
    cond_e cond;
    logic  tsel;
    upc_t  target;
  } uword_t;

  // Status flags from the datapath that the branch logic tests.
  typedef struct packed {
    logic bad_range;
    logic zero_cnt;
    logic hit;
    logic wrap;
    logic no_flush;
    logic prot;
    logic enc_more;
  } flags_t;

  // Control from the sequencer to the datapath and output stage.
  typedef struct packed {
    logic exec;
    act_e act;
    logic tsel;
  } ctrl_t;

  // One drive command without its last mark.
  typedef struct packed {
    cmd_e              command;
    logic [TRK_W-1:0]  track;
    logic [SEC_W-1:0]  sector;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  amount;
    logic              level;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } emit_t;

  // Microprogram addresses.
  localparam upc_t UA_ACCESS  = 5'd0;
  localparam upc_t UA_DEC     = 5'd8;
  localparam upc_t UA_ENDCHK  = 5'd11;
  localparam upc_t UA_WT      = 5'd12;
  localparam upc_t UA_ENC     = 5'd13;
  localparam upc_t UA_IDLE    = 5'd20;
  localparam upc_t UA_HOME    = 5'd21;
  localparam upc_t UA_END     = 5'd26;

  // Target select: request track or cached track.
  localparam logic TS_REQ    = 1'b0;
  localparam logic TS_CACHED = 1'b1;

  // Microprogram read-only table.
  function automatic uword_t ucode_rom(upc_t a);
    uword_t w;
    w = '{act: ACT_FINISH, cond: C_NEVER, tsel: TS_REQ, target: UA_END};
    case (a)
      // Sector access: checks, track load, decode, transfer and write-back checks.
      5'd0:  w = '{ACT_NOP,         C_BAD_RANGE, TS_REQ,    UA_END};
      5'd1:  w = '{ACT_NOP,         C_ZERO_CNT,  TS_REQ,    UA_ENDCHK};
      5'd2:  w = '{ACT_NOP,         C_HIT,       TS_REQ,    UA_DEC};
      5'd3:  w = '{ACT_MOTOR_ON,    C_NEVER,     TS_REQ,    UA_END};
      5'd4:  w = '{ACT_POS_SIDE,    C_NEVER,     TS_REQ,    UA_END};
      5'd5:  w = '{ACT_POS_DIR,     C_NEVER,     TS_REQ,    UA_END};
      5'd6:  w = '{ACT_POS_STEP,    C_NEVER,     TS_REQ,    UA_END};
      5'd7:  w = '{ACT_READ_TRACK,  C_NEVER,     TS_REQ,    UA_END};
      5'd8:  w = '{ACT_DECODE,      C_NEVER,     TS_REQ,    UA_END};
      5'd9:  w = '{ACT_XFER,        C_NEVER,     TS_REQ,    UA_END};
      5'd10: w = '{ACT_NOP,         C_WRAP,      TS_REQ,    UA_WT};
      5'd11: w = '{ACT_NOP,         C_NO_FLUSH,  TS_REQ,    UA_END};
      // Track write-back routine.
      5'd12: w = '{ACT_WT_BEGIN,    C_PROT,      TS_CACHED, UA_END};
      5'd13: w = '{ACT_ENCODE,      C_ENC_MORE,  TS_CACHED, UA_ENC};
      5'd14: w = '{ACT_REALIGN,     C_NEVER,     TS_CACHED, UA_END};
      5'd15: w = '{ACT_MOTOR_ON,    C_NEVER,     TS_CACHED, UA_END};
      5'd16: w = '{ACT_POS_SIDE,    C_NEVER,     TS_CACHED, UA_END};
      5'd17: w = '{ACT_POS_DIR,     C_NEVER,     TS_CACHED, UA_END};
      5'd18: w = '{ACT_POS_STEP,    C_NEVER,     TS_CACHED, UA_END};
      5'd19: w = '{ACT_WRITE_TRACK, C_ALWAYS,    TS_CACHED, UA_END};
      // Idle timeout.
      5'd20: w = '{ACT_MOTOR_OFF,   C_ALWAYS,    TS_REQ,    UA_END};
      // Home sequence.
      5'd21: w = '{ACT_MOTOR_ON,    C_NEVER,     TS_REQ,    UA_END};
      5'd22: w = '{ACT_DIR_OUT,     C_NEVER,     TS_REQ,    UA_END};
      5'd23: w = '{ACT_HOME,        C_NEVER,     TS_REQ,    UA_END};
      5'd24: w = '{ACT_DIR_IN,      C_NEVER,     TS_REQ,    UA_END};
      5'd25: w = '{ACT_SIDE_LOW,    C_ALWAYS,    TS_REQ,    UA_END};
      5'd26: w = '{ACT_FINISH,      C_NEVER,     TS_REQ,    UA_END};
      default: w = '{ACT_FINISH,    C_NEVER,     TS_REQ,    UA_END};
    endcase
    return w;
  endfunction

endpackage

/* rtl/ftcs_in_if.sv */
// ----------------------------------------------------------------------------
// Access request channel
// Valid/ready channel that carries one sector piece access, timeout or home.
// ----------------------------------------------------------------------------
interface ftcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] track_number;
  logic [3:0] sector_number;
  logic [8:0] byte_offset;
  logic [9:0] byte_count;
  logic       is_write;
  logic       request_end;
  logic       write_protected;

  modport source (
    output valid, op, track_number, sector_number, byte_offset, byte_count,
           is_write, request_end, write_protected,
    input  ready
  );
  modport sink (
    input  valid, op, track_number, sector_number, byte_offset, byte_count,
           is_write, request_end, write_protected,
    output ready
  );
endinterface

/* rtl/ftcs_out_if.sv */
// ----------------------------------------------------------------------------
// Drive command channel
// Valid/ready channel that carries one drive command with its last mark.
// ----------------------------------------------------------------------------
interface ftcs_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [7:0] cmd_track;
  logic [3:0] cmd_sector;
  logic [8:0] cmd_offset;
  logic [9:0] cmd_amount;
  logic       cmd_level;
  logic       last;

  modport source (
    output valid, command, cmd_track, cmd_sector, cmd_offset, cmd_amount,
           cmd_level, last,
    input  ready
  );
  modport sink (
    input  valid, command, cmd_track, cmd_sector, cmd_offset, cmd_amount,
           cmd_level, last,
    output ready
  );
endinterface

/* rtl/ftcs_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes the precompensation start track.
// ----------------------------------------------------------------------------
interface ftcs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/ftcs_useq.sv */
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter, microprogram table and conditional branch logic.
// ----------------------------------------------------------------------------
module ftcs_useq
  import ftcs_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  op_e    op_i,
  input  flags_t flags_i,
  input  logic   ok_i,
  output logic   busy_o,
  output ctrl_t  ctrl_o
);

  logic   busy_q, busy_d;
  upc_t   pc_q, pc_d;
  uword_t word;
  logic   take;
  logic   exec;

  assign word   = ucode_rom(pc_q);
  assign exec   = busy_q && ok_i;
  assign busy_o = busy_q;
  assign ctrl_o = '{exec: exec, act: word.act, tsel: word.tsel};

  // Branch condition select.
  always_comb begin
    case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_BAD_RANGE: take = flags_i.bad_range;
      C_ZERO_CNT:  take = flags_i.zero_cnt;
      C_HIT:       take = flags_i.hit;
      C_WRAP:      take = flags_i.wrap;
      C_NO_FLUSH:  take = flags_i.no_flush;
      C_PROT:      take = flags_i.prot;
      C_ENC_MORE:  take = flags_i.enc_more;
      default:     take = 1'b0;
    endcase
  end

  // Dispatch on a new request, then step or branch each cycle not stalled by the output.
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (start_i) begin
      busy_d = 1'b1;
      case (op_i)
        OP_ACCESS: pc_d = UA_ACCESS;
        OP_IDLE:   pc_d = UA_IDLE;
        OP_HOME:   pc_d = UA_HOME;
        default:   pc_d = UA_END;
      endcase
    end else if (exec) begin
      if (word.act == ACT_FINISH) begin
        busy_d = 1'b0;
      end else if (take) begin
        pc_d = word.target;
      end else begin
        pc_d = pc_q + upc_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= UA_END;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

endmodule

/* rtl/ftcs_datapath.sv */
// ----------------------------------------------------------------------------
// Sequencer datapath
// Request latch, cache and drive state, and the command generator that the
// microcode actions drive.
// ----------------------------------------------------------------------------
module ftcs_datapath
  import ftcs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TRK_W-1:0] trk_i,
  input  logic [SEC_W-1:0] sec_i,
  input  logic [OFF_W-1:0] off_i,
  input  logic [CNT_W-1:0] cnt_i,
  input  logic             wr_i,
  input  logic             end_i,
  input  logic             prot_i,
  input  logic             cfg_we_i,
  input  logic [TRK_W-1:0] cfg_data_i,
  input  ctrl_t            ctrl_i,
  output flags_t           flags_o,
  output emit_t            emit_o
);

  // Latched request fields.
  logic [TRK_W-1:0] trk_q;
  logic [SEC_W-1:0] sec_q;
  logic [OFF_W-1:0] off_q;
  logic [CNT_W-1:0] cnt_q;
  logic             wr_q, end_q, prot_q;

  // Cache and drive state.
  logic [TRK_W-1:0]   precomp_q;
  logic [TRK_W-1:0]   cached_q, cached_d;
  logic               valid_q, valid_d;
  logic [TRK_W-1:0]   head_q, head_d;
  logic               motor_q, motor_d;
  logic [SECTORS-1:0] decoded_q, decoded_d;
  logic [SECTORS-1:0] dirty_q, dirty_d;
  logic               pending_q, pending_d;
  logic [SEC_W-1:0]   enc_q, enc_d;

  logic [TRK_W-1:0] tgt;
  logic [TRK_W-1:0] diff;
  logic             tgt_above;
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] clipped;

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      trk_q  <= trk_i;
      sec_q  <= sec_i;
      off_q  <= off_i;
      cnt_q  <= cnt_i;
      wr_q   <= wr_i;
      end_q  <= end_i;
      prot_q <= prot_i;
    end
  end

  // Positioning target and byte count clipping.
  assign tgt       = (ctrl_i.tsel == TS_CACHED) ? cached_q : trk_q;
  assign tgt_above = tgt > head_q;
  assign diff      = tgt_above ? (tgt - head_q) : (head_q - tgt);
  assign room      = CNT_W'(SECTOR_BYTES) - {1'b0, off_q};
  assign clipped   = (cnt_q > room) ? room : cnt_q;

  // Branch flags.
  assign flags_o.bad_range = (trk_q >= TRK_W'(TRACKS)) || (sec_q >= SEC_W'(SECTORS)) ||
                             ({1'b0, off_q} >= CNT_W'(SECTOR_BYTES));
  assign flags_o.zero_cnt  = (cnt_q == '0);
  assign flags_o.hit       = valid_q && (cached_q == trk_q);
  assign flags_o.wrap      = (sec_q == LAST_SECTOR) && pending_q;
  assign flags_o.no_flush  = !(end_q && pending_q);
  assign flags_o.prot      = prot_q;
  assign flags_o.enc_more  = (enc_q != LAST_SECTOR);

  // Action decode: next state and the command to emit.
  always_comb begin
    cached_d  = cached_q;
    valid_d   = valid_q;
    head_d    = head_q;
    motor_d   = motor_q;
    decoded_d = decoded_q;
    dirty_d   = dirty_q;
    pending_d = pending_q;
    enc_d     = enc_q;
    emit_o    = '0;
    if (ctrl_i.exec) begin
      case (ctrl_i.act)
        ACT_MOTOR_ON: begin
          if (!motor_q) begin
            emit_o.valid       = 1'b1;
            emit_o.cmd.command = CMD_MOTOR_ON;
            motor_d            = 1'b1;
          end
        end
        ACT_MOTOR_OFF: begin
          if (motor_q) begin
            emit_o.valid       = 1'b1;
            emit_o.cmd.command = CMD_MOTOR_OFF;
            motor_d            = 1'b0;
          end
        end
        ACT_POS_SIDE: begin
          if (tgt[0] != head_q[0]) begin
            emit_o.valid       = 1'b1;
            emit_o.cmd.command = CMD_SIDE;
            emit_o.cmd.level   = tgt[0];
            head_d             = tgt[0] ? (head_q + TRK_W'(1)) : (head_q - TRK_W'(1));
          end
        end
        ACT_POS_DIR: begin
          if (tgt != head_q) begin
            emit_o.valid       = 1'b1;
            emit_o.cmd.command = CMD_DIRECTION;
            emit_o.cmd.level   = tgt_above;
          end
        end
        ACT_POS_STEP: begin
          if (tgt != head_q) begin
            emit_o.valid       = 1'b1;
            emit_o.cmd.command = CMD_STEP;
            emit_o.cmd.amount  = CNT_W'(diff[TRK_W-1:1]);
            head_d             = tgt;
          end
        end
        ACT_READ_TRACK: begin
          emit_o.valid       = 1'b1;
          emit_o.cmd.command = CMD_READ_TRACK;
          emit_o.cmd.track   = trk_q;
          emit_o.cmd.level   = (trk_q >= precomp_q);
          cached_d           = trk_q;
          valid_d            = 1'b1;
          decoded_d          = '0;
          dirty_d            = '0;
        end
        ACT_DECODE: begin
          if (!decoded_q[sec_q]) begin
            emit_o.valid       = 1'b1;
            emit_o.cmd.command = CMD_DECODE;
            emit_o.cmd.sector  = sec_q;
            decoded_d[sec_q]   = 1'b1;
          end
        end
        ACT_XFER: begin
          emit_o.valid       = 1'b1;
          emit_o.cmd.command = wr_q ? CMD_WRITE_BYTES : CMD_READ_BYTES;
          emit_o.cmd.sector  = sec_q;
          emit_o.cmd.offset  = off_q;
          emit_o.cmd.amount  = clipped;
          if (wr_q) begin
            dirty_d[sec_q] = 1'b1;
            pending_d      = 1'b1;
          end
        end
        ACT_WT_BEGIN: begin
          pending_d = 1'b0;
          enc_d     = '0;
          if (prot_q) begin
            emit_o.valid       = 1'b1;
            emit_o.cmd.command = CMD_PROT_ERR;
            emit_o.cmd.track   = cached_q;
          end
        end
        ACT_ENCODE: begin
          if (dirty_q[enc_q]) begin
            emit_o.valid       = 1'b1;
            emit_o.cmd.command = CMD_ENCODE;
            emit_o.cmd.sector  = enc_q;
            dirty_d[enc_q]     = 1'b0;
          end
          enc_d = enc_q + SEC_W'(1);
        end
        ACT_REALIGN: begin
          emit_o.valid       = 1'b1;
          emit_o.cmd.command = CMD_REALIGN;
        end
        ACT_WRITE_TRACK: begin
          emit_o.valid       = 1'b1;
          emit_o.cmd.command = CMD_WRITE_TRACK;
          emit_o.cmd.track   = cached_q;
          emit_o.cmd.level   = (cached_q >= precomp_q);
        end
        ACT_DIR_OUT: begin
          emit_o.valid       = 1'b1;
          emit_o.cmd.command = CMD_DIRECTION;
        end
        ACT_HOME: begin
          emit_o.valid       = 1'b1;
          emit_o.cmd.command = CMD_HOME;
        end
        ACT_DIR_IN: begin
          emit_o.valid       = 1'b1;
          emit_o.cmd.command = CMD_DIRECTION;
          emit_o.cmd.level   = 1'b1;
        end
        ACT_SIDE_LOW: begin
          emit_o.valid       = 1'b1;
          emit_o.cmd.command = CMD_SIDE;
          head_d             = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precomp_q <= PRECOMP_RESET;
      cached_q  <= '0;
      valid_q   <= 1'b0;
      head_q    <= '0;
      motor_q   <= 1'b0;
      decoded_q <= '0;
      dirty_q   <= '0;
      pending_q <= 1'b0;
      enc_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        precomp_q <= cfg_data_i;
      end
      cached_q  <= cached_d;
      valid_q   <= valid_d;
      head_q    <= head_d;
      motor_q   <= motor_d;
      decoded_q <= decoded_d;
      dirty_q   <= dirty_d;
      pending_q <= pending_d;
      enc_q     <= enc_d;
    end
  end

endmodule

/* rtl/ftcs_out_stage.sv */
// ----------------------------------------------------------------------------
// Command output stage
// Holds the newest command back by one so that the last command of a request
// can be marked, and drives the output register of the command channel.
// ----------------------------------------------------------------------------
module ftcs_out_stage
  import ftcs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  emit_t emit_i,
  input  logic  finish_i,
  input  logic  out_ready_i,
  output logic  ok_o,
  output logic  out_valid_o,
  output cmd_t  out_cmd_o,
  output logic  out_last_o
);

  logic pend_v_q, pend_v_d;
  cmd_t pend_q, pend_d;
  logic out_v_q, out_v_d;
  cmd_t out_q, out_d;
  logic last_q, last_d;
  logic out_free;

  assign out_free    = !out_v_q || out_ready_i;
  assign ok_o        = !pend_v_q || out_free;
  assign out_valid_o = out_v_q;
  assign out_cmd_o   = out_q;
  assign out_last_o  = last_q;

  // Hold-back and output register update.
  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && !out_ready_i;
    out_d    = out_q;
    last_d   = last_q;
    if (emit_i.valid) begin
      if (pend_v_q) begin
        out_v_d = 1'b1;
        out_d   = pend_q;
        last_d  = 1'b0;
      end
      pend_v_d = 1'b1;
      pend_d   = emit_i.cmd;
    end else if (finish_i && pend_v_q) begin
      out_v_d  = 1'b1;
      out_d    = pend_q;
      last_d   = 1'b1;
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

endmodule

/* rtl/floppy_track_cache_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// Floppy track cache sequencer
// Microcoded sequencer that turns sector piece accesses, idle timeouts and
// home events into an ordered stream of drive commands.
// ----------------------------------------------------------------------------
// Throughput: one microcode step per cycle while the output stage is not stalled;
// the 11-step encode loop dominates a track write.
// A request is taken only when the sequencer is idle; output stalls stop it.
// Reset: cache invalid, motor off, head at track zero, precompensation from 80.
// ----------------------------------------------------------------------------
module floppy_track_cache_sequencer_unit
  import ftcs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  ftcs_in_if.sink      req_i,
  ftcs_out_if.source   rsp_o,
  ftcs_cfg_if.sink     cfg_i
);

  logic   start;
  logic   busy;
  logic   ok;
  flags_t flags;
  ctrl_t  ctrl;
  emit_t  emit;
  cmd_t   out_cmd;
  op_e    op;

  // Request and configuration handshakes.
  assign req_i.ready = !busy;
  assign start       = req_i.valid && !busy;
  assign op          = op_e'(req_i.op);
  assign cfg_i.ready = 1'b1;

  // Step counter and microprogram.
  ftcs_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (op),
    .flags_i (flags),
    .ok_i    (ok),
    .busy_o  (busy),
    .ctrl_o  (ctrl)
  );

  // Cache state and command generation.
  ftcs_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .trk_i      (req_i.track_number),
    .sec_i      (req_i.sector_number),
    .off_i      (req_i.byte_offset),
    .cnt_i      (req_i.byte_count),
    .wr_i       (req_i.is_write),
    .end_i      (req_i.request_end),
    .prot_i     (req_i.write_protected),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .ctrl_i     (ctrl),
    .flags_o    (flags),
    .emit_o     (emit)
  );

  // Last-mark hold-back and output register.
  ftcs_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .finish_i    (ctrl.exec && (ctrl.act == ACT_FINISH)),
    .out_ready_i (rsp_o.ready),
    .ok_o        (ok),
    .out_valid_o (rsp_o.valid),
    .out_cmd_o   (out_cmd),
    .out_last_o  (rsp_o.last)
  );

  assign rsp_o.command    = out_cmd.command;
  assign rsp_o.cmd_track  = out_cmd.track;
  assign rsp_o.cmd_sector = out_cmd.sector;
  assign rsp_o.cmd_offset = out_cmd.offset;
  assign rsp_o.cmd_amount = out_cmd.amount;
  assign rsp_o.cmd_level  = out_cmd.level;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track cache sequencer testbench
// Drives access, timeout and home requests into the sequencer and checks every
// drive command against a cycle-free model of the cache, head and motor. Runs
// under several precompensation settings and three idling patterns. One long
// output stall backs the sequencer up into its request port.
// ----------------------------------------------------------------------------
module tb
  import ftcs_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int unsigned MAX_CMDS_PER_REQ = 32;
  localparam int unsigned DRAIN_CYCLES     = 40;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned PHASES           = 6;
  localparam int unsigned ITEMS_PER_PHASE  = 70;

  // One request as seen on the access channel.
  typedef struct packed {
    op_e              op;
    logic [TRK_W-1:0] track;
    logic [SEC_W-1:0] sector;
    logic [OFF_W-1:0] offset;
    logic [CNT_W-1:0] count;
    logic             is_write;
    logic             request_end;
    logic             write_protected;
  } access_t;

  // One drive command together with its last mark.
  typedef struct packed {
    cmd_t cmd;
    logic last;
  } drive_cmd_t;

  // Model of the track cache, head position and motor, plus the queue of
  // drive commands it has predicted but not yet seen.
  class drive_command_scoreboard;
    logic [TRK_W-1:0] precomp_from;
    logic [TRK_W-1:0] cached_track;
    bit               cache_valid;
    logic [TRK_W-1:0] head_track;
    bit               step_inward;
    bit               motor_running;
    bit               decoded [SECTORS];
    bit               dirty [SECTORS];
    bit               write_pending;
    cmd_t             batch [$];
    drive_cmd_t       expected_q [$];
    int unsigned      errors;
    int unsigned      requests;
    int unsigned      commands;
    bit               seen [16];

    function new();
      precomp_from  = PRECOMP_RESET;
      cached_track  = '0;
      cache_valid   = 1'b0;
      head_track    = '0;
      step_inward   = 1'b1;
      motor_running = 1'b0;
      write_pending = 1'b0;
      foreach (decoded[i]) begin
        decoded[i] = 1'b0;
        dirty[i]   = 1'b0;
      end
      errors   = 0;
      requests = 0;
      commands = 0;
    endfunction

    function bit out_of_range(access_t r);
      return r.track >= TRACKS || r.sector >= SECTORS || r.offset >= SECTOR_BYTES;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Commands past the per-request cap are dropped by the model.
    function void emit(cmd_e code, logic [TRK_W-1:0] trk, logic [SEC_W-1:0] sec,
                       logic [OFF_W-1:0] off, logic [CNT_W-1:0] amt, logic lvl);
      cmd_t c;
      if (batch.size() >= MAX_CMDS_PER_REQ) return;
      c.command = code;
      c.track   = trk;
      c.sector  = sec;
      c.offset  = off;
      c.amount  = amt;
      c.level   = lvl;
      batch.push_back(c);
    endfunction

    function void start_motor();
      if (!motor_running) begin
        emit(CMD_MOTOR_ON, '0, '0, '0, '0, 1'b0);
        motor_running = 1'b1;
      end
    endfunction

    // Side select first when the parity differs, then direction and steps
    // of two tracks (one cylinder) each.
    function void position_head(logic [TRK_W-1:0] trk);
      int diff;
      if (trk[0] != head_track[0]) begin
        emit(CMD_SIDE, '0, '0, '0, '0, trk[0]);
        head_track = trk[0] ? head_track + 8'd1 : head_track - 8'd1;
      end
      if (trk != head_track) begin
        step_inward = trk > head_track;
        emit(CMD_DIRECTION, '0, '0, '0, '0, step_inward);
        diff = int'(trk) - int'(head_track);
        if (diff < 0) diff = -diff;
        emit(CMD_STEP, '0, '0, '0, CNT_W'(diff / 2), 1'b0);
        head_track = trk;
      end
    endfunction

    // Write the cached track back, or report protection and drop the flush.
    function void write_back(bit prot);
      int i;
      write_pending = 1'b0;
      if (prot) begin
        emit(CMD_PROT_ERR, cached_track, '0, '0, '0, 1'b0);
        return;
      end
      for (i = 0; i < SECTORS; i++) begin
        if (dirty[i]) begin
          emit(CMD_ENCODE, '0, SEC_W'(i), '0, '0, 1'b0);
          dirty[i] = 1'b0;
        end
      end
      emit(CMD_REALIGN, '0, '0, '0, '0, 1'b0);
      start_motor();
      position_head(cached_track);
      emit(CMD_WRITE_TRACK, cached_track, '0, '0, '0, cached_track >= precomp_from);
    endfunction

    function void access_piece(access_t r);
      int unsigned cnt;
      int unsigned room;
      int i;
      if (out_of_range(r)) return;
      cnt = r.count;
      if (cnt != 0) begin
        // A miss loads the new track; dirty data of the old one are lost.
        if (!cache_valid || cached_track != r.track) begin
          start_motor();
          position_head(r.track);
          emit(CMD_READ_TRACK, r.track, '0, '0, '0, r.track >= precomp_from);
          cached_track = r.track;
          cache_valid  = 1'b1;
          for (i = 0; i < SECTORS; i++) begin
            decoded[i] = 1'b0;
            dirty[i]   = 1'b0;
          end
        end
        if (!decoded[r.sector]) begin
          emit(CMD_DECODE, '0, r.sector, '0, '0, 1'b0);
          decoded[r.sector] = 1'b1;
        end
        room = SECTOR_BYTES - r.offset;
        if (cnt > room) cnt = room;
        if (r.is_write) begin
          emit(CMD_WRITE_BYTES, '0, r.sector, r.offset, CNT_W'(cnt), 1'b0);
          dirty[r.sector] = 1'b1;
          write_pending   = 1'b1;
        end else begin
          emit(CMD_READ_BYTES, '0, r.sector, r.offset, CNT_W'(cnt), 1'b0);
        end
        if (r.sector == LAST_SECTOR && write_pending) write_back(r.write_protected);
      end
      if (r.request_end && write_pending) write_back(r.write_protected);
    endfunction

    // Work out the commands an accepted request causes and queue them.
    function void note_request(access_t r);
      drive_cmd_t d;
      batch.delete();
      requests++;
      case (r.op)
        OP_ACCESS: access_piece(r);
        OP_IDLE: begin
          if (motor_running) begin
            emit(CMD_MOTOR_OFF, '0, '0, '0, '0, 1'b0);
            motor_running = 1'b0;
          end
        end
        OP_HOME: begin
          start_motor();
          emit(CMD_DIRECTION, '0, '0, '0, '0, 1'b0);
          emit(CMD_HOME, '0, '0, '0, '0, 1'b0);
          emit(CMD_DIRECTION, '0, '0, '0, '0, 1'b1);
          emit(CMD_SIDE, '0, '0, '0, '0, 1'b0);
          step_inward = 1'b1;
          head_track  = '0;
        end
        default: ;
      endcase
      foreach (batch[i]) begin
        d.cmd  = batch[i];
        d.last = (i == batch.size() - 1);
        expected_q.push_back(d);
      end
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Check one accepted drive command against the oldest prediction.
    function void check_command(drive_cmd_t got);
      drive_cmd_t want;
      commands++;
      seen[got.cmd.command] = 1'b1;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected drive command %0d, expected none, actual %0d",
                 $time, got.cmd.command, got.cmd.command);
        return;
      end
      want = expected_q.pop_front();
      compare("command", want.cmd.command, got.cmd.command);
      compare("cmd_track", want.cmd.track, got.cmd.track);
      compare("cmd_sector", want.cmd.sector, got.cmd.sector);
      compare("cmd_offset", want.cmd.offset, got.cmd.offset);
      compare("cmd_amount", want.cmd.amount, got.cmd.amount);
      compare("cmd_level", want.cmd.level, got.cmd.level);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_requested = 0;
  int unsigned cycle_count = 0;

  drive_command_scoreboard sb = new();

  ftcs_in_if  req_if ();
  ftcs_out_if rsp_if ();
  ftcs_cfg_if cfg_if ();

  floppy_track_cache_sequencer_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d drive commands outstanding",
               cycle_count, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic access_t make_access(int unsigned trk, int unsigned sec,
                                          int unsigned off, int unsigned cnt,
                                          bit wr, bit req_last, bit prot);
    access_t r;
    r.op              = OP_ACCESS;
    r.track           = TRK_W'(trk);
    r.sector          = SEC_W'(sec);
    r.offset          = OFF_W'(off);
    r.count           = CNT_W'(cnt);
    r.is_write        = wr;
    r.request_end     = req_last;
    r.write_protected = prot;
    return r;
  endfunction

  // Offer one request, with a random gap first, and wait for it to be taken.
  task automatic send_request(input access_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.op              <= r.op;
    req_if.track_number    <= r.track;
    req_if.sector_number   <= r.sector;
    req_if.byte_offset     <= r.offset;
    req_if.byte_count      <= r.count;
    req_if.is_write        <= r.is_write;
    req_if.request_end     <= r.request_end;
    req_if.write_protected <= r.write_protected;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(r);
  endtask

  // Let every predicted command drain, then give the sequencer time to
  // finish any request that causes no command.
  task automatic wait_until_idle();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Command receiver: checks each accepted command and stalls at random.
  // A hold-off request keeps ready low for a long stretch.
  initial begin
    drive_cmd_t  got;
    int unsigned hold_served;
    int unsigned hold_left;
    hold_served = 0;
    hold_left   = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.cmd.command = cmd_e'(rsp_if.command);
        got.cmd.track   = rsp_if.cmd_track;
        got.cmd.sector  = rsp_if.cmd_sector;
        got.cmd.offset  = rsp_if.cmd_offset;
        got.cmd.amount  = rsp_if.cmd_amount;
        got.cmd.level   = rsp_if.cmd_level;
        got.last        = rsp_if.last;
        sb.check_command(got);
      end
      if (hold_served != hold_requested) begin
        hold_served = hold_requested;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Main sequence: reset, then phases of configuration and requests.
  initial begin
    access_t         r;
    logic [TRK_W-1:0] setting;
    logic [TRK_W-1:0] trk;
    logic [SEC_W-1:0] sec;
    int unsigned     phase;
    int unsigned     done;
    int unsigned     pieces;
    int unsigned     off;
    int unsigned     k;
    int unsigned     codes;
    bit              wr;
    bit              prot;

    req_if.valid           <= 1'b0;
    req_if.op              <= OP_ACCESS;
    req_if.track_number    <= '0;
    req_if.sector_number   <= '0;
    req_if.byte_offset     <= '0;
    req_if.byte_count      <= '0;
    req_if.is_write        <= 1'b0;
    req_if.request_end     <= 1'b0;
    req_if.write_protected <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.data            <= '0;
    trk = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (phase = 0; phase < PHASES; phase++) begin
      // Idling pattern: sender light and receiver heavy, then swapped, then none.
      src_idle_pct = (phase < 2) ? 24 : (phase < 4) ? 56 : 0;
      snk_idle_pct = (phase < 2) ? 56 : (phase < 4) ? 24 : 0;
      wait_until_idle();

      case (phase)
        0:       setting = 8'd0;
        1:       setting = 8'd255;
        2:       setting = TRK_W'($urandom_range(1, 254));
        3:       setting = 8'(TRACKS - 1);
        4:       setting = 8'(TRACKS);
        default: setting = PRECOMP_RESET;
      endcase
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= setting;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      cfg_if.valid <= 1'b0;
      sb.precomp_from = setting;

      // Directed requests: cache miss and hit, clipping, track wrap, request
      // end flush, protection, ignored requests, timeout and home.
      if (phase == 0) begin
        send_request(make_access(0, 0, 0, 1, 0, 0, 0));
        send_request(make_access(0, 0, 511, 512, 1, 0, 0));
        send_request(make_access(0, 4, 100, 1023, 1, 0, 0));
        send_request(make_access(0, 10, 0, 512, 1, 0, 0));
        send_request(make_access(159, 5, 0, 16, 1, 1, 0));
        send_request(make_access(1, 3, 8, 0, 0, 1, 0));
        send_request(make_access(2, 2, 0, 8, 1, 0, 0));
        send_request(make_access(6, 10, 0, 8, 0, 1, 1));
        send_request(make_access(6, 1, 0, 4, 1, 1, 1));
        send_request(make_access(160, 0, 0, 1, 1, 1, 0));
        send_request(make_access(255, 15, 511, 1023, 1, 1, 1));
        send_request(make_access(7, 11, 0, 1, 0, 0, 0));
        r = make_access(3, 2, 0, 1, 1, 1, 0);
        r.op = OP_RSVD;
        send_request(r);
        r.op = OP_IDLE;
        send_request(r);
        send_request(r);
        r.op = OP_HOME;
        send_request(r);
        send_request(r);
        send_request(make_access(77, 0, 0, 512, 1, 0, 0));
        send_request(make_access(77, 3, 0, 0, 0, 1, 0));
        send_request(make_access(9, 6, 511, 1, 1, 0, 0));
        send_request(make_access(11, 6, 0, 1, 0, 1, 0));
      end

      // Long output stall while requests keep coming.
      if (phase == 4) hold_requested++;

      // Random part: mostly multi-piece requests walking through sectors of
      // a track, with timeouts, homes and malformed requests mixed in.
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 72) begin
          if ($urandom_range(0, 2) == 0) trk = TRK_W'($urandom_range(0, TRACKS - 1));
          sec    = SEC_W'($urandom_range(0, SECTORS - 1));
          pieces = $urandom_range(1, 6);
          wr     = $urandom_range(0, 1);
          prot   = ($urandom_range(0, 11) == 0);
          for (k = 0; k < pieces; k++) begin
            off = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, SECTOR_BYTES - 1);
            send_request(make_access(trk, sec, off, $urandom_range(1, SECTOR_BYTES - off),
                                     ($urandom_range(0, 3) == 0) ? !wr : wr,
                                     k == pieces - 1, prot));
            done++;
            // Track wrap continues on the next track.
            if (sec == LAST_SECTOR) begin
              sec = '0;
              if (trk < TRACKS - 1) trk = trk + 8'd1;
            end else begin
              sec = sec + 4'd1;
            end
          end
        end else begin
          r = make_access($urandom_range(0, TRACKS - 1), $urandom_range(0, SECTORS - 1),
                          $urandom_range(0, SECTOR_BYTES - 1), $urandom_range(1, 512),
                          $urandom_range(0, 1), $urandom_range(0, 1),
                          $urandom_range(0, 7) == 0);
          case ($urandom_range(0, 7))
            0: r.op = OP_IDLE;
            1: r.op = OP_HOME;
            2: r.op = OP_RSVD;
            3: r.track = TRK_W'($urandom_range(TRACKS, 255));
            4: r.sector = SEC_W'($urandom_range(SECTORS, 15));
            5: r.count = '0;
            6: r.count = CNT_W'($urandom_range(513, 1023));
            default: begin
              r.op     = op_e'($urandom_range(0, 3));
              r.track  = TRK_W'($urandom);
              r.sector = SEC_W'($urandom);
              r.count  = CNT_W'($urandom);
            end
          endcase
          send_request(r);
          // Requests the sequencer ignores do not count.
          if (r.op != OP_RSVD && !(r.op == OP_ACCESS && sb.out_of_range(r))) done++;
        end
      end
    end

    wait_until_idle();

    codes = 0;
    foreach (sb.seen[i]) codes += sb.seen[i];
    $display("Ran %0d requests over %0d precompensation settings and three idling patterns,",
             sb.requests, PHASES);
    $display("checked %0d drive commands covering %0d command codes, with one long stall.",
             sb.commands, codes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
